// File: src/kscs_pkg.sv
// Package: shared constants, cell entry and cell control types for the selector.
`timescale 1ns / 1ps
package kscs_pkg;

  localparam int MAX_MODES  = 8;
  localparam int MAX_HIDDEN = 4096;
  localparam int COST_BITS  = 32;
  localparam int INDEX_BITS = 12;
  localparam int RANK_BITS  = 3;
  localparam int MODE_BITS  = 4;
  localparam int COUNT_BITS = 13;
  localparam int SUM_BITS   = 40;
  localparam int TOTAL_BITS = 48;

  localparam logic signed [COST_BITS-1:0] COST_MAX = {1'b0, {(COST_BITS-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic signed [COST_BITS-1:0] cost;
    logic [INDEX_BITS-1:0]       index;
    logic                        valid;
  } entry_t;

  typedef struct packed {
    cell_op_t                    op;
    logic signed [COST_BITS-1:0] cost;
    logic [INDEX_BITS-1:0]       index;
  } cell_ctrl_t;

  localparam entry_t ENTRY_EMPTY = '{cost: COST_MAX, index: '0, valid: 1'b0};

endpackage

// File: src/kscs_in_if.sv
// Interface: input cost channel with valid/ready handshake.
`timescale 1ns / 1ps
interface kscs_in_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [kscs_pkg::COST_BITS-1:0]        cost;
  logic                                         last_of_type;
  logic                                         first_of_set;

  modport source (output valid, cost, last_of_type, first_of_set, input ready);
  modport sink   (input valid, cost, last_of_type, first_of_set, output ready);
endinterface

// File: src/kscs_out_if.sv
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface kscs_out_if;
  logic                                         valid;
  logic                                         ready;
  logic [kscs_pkg::RANK_BITS-1:0]               rank;
  logic [kscs_pkg::INDEX_BITS-1:0]              hidden_index;
  logic signed [kscs_pkg::COST_BITS-1:0]        selected_cost;
  logic                                         slot_filled;
  logic signed [kscs_pkg::SUM_BITS-1:0]         type_sum;
  logic signed [kscs_pkg::TOTAL_BITS-1:0]       running_total;
  logic                                         last_of_run;

  modport source (output valid, rank, hidden_index, selected_cost, slot_filled,
                  type_sum, running_total, last_of_run, input ready);
  modport sink   (input valid, rank, hidden_index, selected_cost, slot_filled,
                  type_sum, running_total, last_of_run, output ready);
endinterface

// File: src/k_smallest_cost_selector_core.sv
// Top level: k-smallest cost selector built from a chain of sorting cells.
//
// Costs enter on the "costs" channel, one transfer per cycle while the block
// is idle, and are numbered by arrival within their type. A chain of MAX_MODES
// cells keeps the smallest costs in rank order (earlier arrival wins ties).
// The transfer that carries last_of_type is inserted like any other; then the
// block stops taking costs, rotates the chain once around to add up the first
// modes_in_use ranks (modes_in_use 0 acts as 1, above MAX_MODES as MAX_MODES),
// updates the running total, and sends that many results on the "results"
// channel, one per cycle while the receiver takes them, rank 0 first. Results
// sit in an output register; a stalled receiver holds the emit phase but costs
// are taken again as soon as the final result is loaded. The user must write
// modes_in_use through cfg_we/cfg_data only while idle; the block does not
// enforce this.
// Synchronous reset empties the chain, clears the arrival count and the
// running total, and sets modes_in_use to 1.
`timescale 1ns / 1ps
module k_smallest_cost_selector_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kscs_pkg::MODE_BITS-1:0]  cfg_data,
  kscs_in_if.sink                         costs,
  kscs_out_if.source                      results
);
  import kscs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_TOTAL,
    ST_EMIT
  } state_t;

  state_t                         state;
  logic [MODE_BITS-1:0]           modes;
  logic [COUNT_BITS-1:0]          count;
  logic [RANK_BITS-1:0]           step;
  logic signed [SUM_BITS-1:0]     sum_acc;
  logic signed [TOTAL_BITS-1:0]   total;

  logic                           out_valid;
  logic [RANK_BITS-1:0]           out_rank;
  logic [INDEX_BITS-1:0]          out_index;
  logic signed [COST_BITS-1:0]    out_cost;
  logic                           out_filled;
  logic signed [SUM_BITS-1:0]     out_sum;
  logic signed [TOTAL_BITS-1:0]   out_total;
  logic                           out_last;

  entry_t                         ent [MAX_MODES];
  logic                           ins [MAX_MODES];
  cell_ctrl_t                     ctrl;

  logic [MODE_BITS-1:0]           m_eff;
  logic [MODE_BITS-1:0]           m_last;
  logic                           step_is_last;
  logic                           accept;
  logic                           load;
  logic                           room;
  logic signed [TOTAL_BITS:0]     total_wide;
  logic signed [TOTAL_BITS-1:0]   total_next;

  assign costs.ready = (state == ST_IDLE);
  assign accept      = costs.valid && costs.ready;
  assign load        = (state == ST_EMIT) && (!out_valid || results.ready);
  assign room        = (count < COUNT_BITS'(MAX_HIDDEN));

  always_comb begin
    if (modes == '0) begin
      m_eff = MODE_BITS'(1);
    end else if (modes > MODE_BITS'(MAX_MODES)) begin
      m_eff = MODE_BITS'(MAX_MODES);
    end else begin
      m_eff = modes;
    end
    m_last       = m_eff - MODE_BITS'(1);
    step_is_last = ({{(MODE_BITS-RANK_BITS){1'b0}}, step} == m_last);
  end

  always_comb begin
    total_wide = {total[TOTAL_BITS-1], total}
               + {{(TOTAL_BITS+1-SUM_BITS){sum_acc[SUM_BITS-1]}}, sum_acc};
    if (total_wide[TOTAL_BITS] != total_wide[TOTAL_BITS-1]) begin
      total_next = total_wide[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                          : {1'b0, {(TOTAL_BITS-1){1'b1}}};
    end else begin
      total_next = total_wide[TOTAL_BITS-1:0];
    end
  end

  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.cost  = costs.cost;
    ctrl.index = count[INDEX_BITS-1:0];
    case (state)
      ST_IDLE: begin
        if (accept && room) begin
          ctrl.op = OP_INSERT;
        end
      end
      ST_SUM:  ctrl.op = OP_ROTATE;
      ST_EMIT: begin
        if (load) begin
          ctrl.op = step_is_last ? OP_CLEAR : OP_ROTATE;
        end
      end
      default: ctrl.op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < MAX_MODES; i++) begin : g_cell
    entry_t left_ent;
    logic   left_ins;
    if (i == 0) begin : g_head
      assign left_ent = ENTRY_EMPTY;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_ent = ent[i-1];
      assign left_ins = ins[i-1];
    end
    kscs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .left_ent (left_ent),
      .left_ins (left_ins),
      .rot_src  (ent[(i + 1) % MAX_MODES]),
      .ent      (ent[i]),
      .ins      (ins[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      modes     <= MODE_BITS'(1);
      count     <= '0;
      step      <= '0;
      sum_acc   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        modes <= cfg_data;
      end
      if (results.valid && results.ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (costs.first_of_set) begin
              total <= '0;
            end
            if (room) begin
              count <= count + COUNT_BITS'(1);
            end
            if (costs.last_of_type) begin
              state   <= ST_SUM;
              step    <= '0;
              sum_acc <= '0;
            end
          end
        end
        ST_SUM: begin
          if ({{(MODE_BITS-RANK_BITS){1'b0}}, step} < m_eff) begin
            sum_acc <= sum_acc
                     + {{(SUM_BITS-COST_BITS){ent[0].cost[COST_BITS-1]}}, ent[0].cost};
          end
          if (step == RANK_BITS'(MAX_MODES - 1)) begin
            state <= ST_TOTAL;
            step  <= '0;
          end else begin
            step <= step + RANK_BITS'(1);
          end
        end
        ST_TOTAL: begin
          total <= total_next;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            out_valid  <= 1'b1;
            out_rank   <= step;
            out_index  <= ent[0].index;
            out_cost   <= ent[0].cost;
            out_filled <= ent[0].valid;
            out_sum    <= sum_acc;
            out_total  <= total;
            out_last   <= step_is_last;
            if (step_is_last) begin
              state <= ST_IDLE;
              step  <= '0;
              count <= '0;
            end else begin
              step <= step + RANK_BITS'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign results.valid         = out_valid;
  assign results.rank          = out_rank;
  assign results.hidden_index  = out_index;
  assign results.selected_cost = out_cost;
  assign results.slot_filled   = out_filled;
  assign results.type_sum      = out_sum;
  assign results.running_total = out_total;
  assign results.last_of_run   = out_last;

endmodule

// File: src/kscs_cell.sv
// Sorting cell: holds one ranked entry, inserts, shifts from its neighbor, rotates or clears.
`timescale 1ns / 1ps
module kscs_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  kscs_pkg::cell_ctrl_t  ctrl,
  input  kscs_pkg::entry_t      left_ent,
  input  logic                  left_ins,
  input  kscs_pkg::entry_t      rot_src,
  output kscs_pkg::entry_t      ent,
  output logic                  ins
);
  import kscs_pkg::*;

  assign ins = !ent.valid || ($signed(ctrl.cost) < $signed(ent.cost));

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= ENTRY_EMPTY;
    end else begin
      case (ctrl.op)
        OP_INSERT: begin
          if (left_ins) begin
            ent <= left_ent;
          end else if (ins) begin
            ent <= '{cost: ctrl.cost, index: ctrl.index, valid: 1'b1};
          end
        end
        OP_ROTATE: ent <= rot_src;
        OP_CLEAR:  ent <= ENTRY_EMPTY;
        default:   ent <= ent;
      endcase
    end
  end
endmodule
